// ===== sv/bfm_pkg.sv =====
`timescale 1ns / 1ps

package bfm_pkg;

  localparam int MAX_FRAME_LEN = 64;
  localparam int OVERFLOW_POS  = MAX_FRAME_LEN + 9;

  localparam logic [7:0] SYNC_BYTE  = 8'h9A;
  localparam logic [7:0] ACK_BYTE   = 8'h06;
  localparam logic [7:0] MAX_LEN_8  = 8'(MAX_FRAME_LEN);
  localparam logic [7:0] OVF_POS_8  = 8'(OVERFLOW_POS);
  localparam logic [7:0] POS_SYNC   = 8'd0;
  localparam logic [7:0] POS_SENDER = 8'd1;
  localparam logic [7:0] POS_LENGTH = 8'd2;
  localparam logic [7:0] POS_RECV   = 8'd3;
  localparam logic [7:0] POS_EXT    = 8'd4;

  localparam int RESULT_BITS = 50;
  localparam int TDATA_BITS  = 56;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_ERROR = 3'd1,
    ST_TOKEN = 3'd2,
    ST_EMPTY = 3'd3,
    ST_GOOD  = 3'd4,
    ST_BAD   = 3'd5,
    ST_ACK   = 3'd6
  } status_t;

  typedef enum logic {
    REG_CRC_POLY = 1'b0,
    REG_CRC_INIT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [15:0] poly;
    logic [15:0] init;
  } crc_cfg_t;

  typedef struct packed {
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [7:0]  frame_length;
    logic [6:0]  sender_address;
    status_t     frame_status;
  } result_t;

  // msb-first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/bus_frame_monitor_parser.sv =====
`timescale 1ns / 1ps

// bus frame monitor: one bus byte in, one frame status beat out
// s_tdata carries a byte seen on the bus; every byte gives exactly one
// m_tdata beat with the frame status, sender, length and, for a good or bad
// crc status, the received and computed crc-16
// the cfg channel writes the crc polynomial (index 0) and the initial
// value (index 1); cfg_ready is always high, write only while idle
// a byte taken on s_tvalid & s_tready reaches m_tvalid through an input
// register and a result register, with one byte's parse and crc update
// between them
// throughput: one byte per cycle while m_tready is high; the crc byte update is combinational
// when m_tready is low the result register holds its beat and one more
// byte may wait in the input register; s_tready drops only when both
// are full
// reset clears both registers, the frame position and the status history,
// and restores polynomial 0x1021 and initial value 0

module bus_frame_monitor_parser
  import bfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // bus_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // frame_status[2:0], sender_address[9:3], frame_length[17:10],
  // received_crc[33:18], computed_crc[49:34], zero pad [55:50]
  output logic [TDATA_BITS-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data
);

  crc_cfg_t   crc_cfg;
  result_t    result;
  result_t    out_beat;
  logic [7:0] in_byte;
  logic       in_full;
  logic       out_full;
  logic       advance;

  assign advance  = in_full && (!out_full || m_tready);
  assign s_tready = !in_full || advance;

  bfm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .crc_cfg   (crc_cfg)
  );

  bfm_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .bus_byte (in_byte),
    .crc_cfg  (crc_cfg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (advance) begin
      out_beat <= result;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {{(TDATA_BITS - RESULT_BITS){1'b0}}, out_beat};

endmodule

// ===== sv/bfm_cfg_regs.sv =====
`timescale 1ns / 1ps

module bfm_cfg_regs
  import bfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output crc_cfg_t    crc_cfg
);

  logic [15:0] poly;
  logic [15:0] init;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= 16'h1021;
      init <= 16'h0000;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_CRC_POLY: poly <= cfg_data;
        REG_CRC_INIT: init <= cfg_data;
        default: ;
      endcase
    end
  end

  assign crc_cfg.poly = poly;
  assign crc_cfg.init = init;

endmodule

// ===== sv/bfm_parse.sv =====
`timescale 1ns / 1ps

module bfm_parse
  import bfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] bus_byte,
  input  crc_cfg_t   crc_cfg,
  output result_t    result
);

  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  frame_len_hold, frame_len_hold_next;
  status_t     previous_status, previous_status_next;
  logic [6:0]  sender_hold, sender_hold_next;
  logic [15:0] received_crc_hold, received_crc_hold_next;
  logic [15:0] running_crc, running_crc_next;

  logic [15:0] crc_src;
  logic [15:0] crc_fed;
  logic [8:0]  pos_ext;
  logic [8:0]  len_p1;
  logic [8:0]  len_p2;
  status_t     status;

  assign crc_src = (byte_position == POS_SYNC) ? crc_cfg.init : running_crc;
  assign crc_fed = crc_feed(crc_src, bus_byte, crc_cfg.poly);
  assign pos_ext = {1'b0, byte_position};
  assign len_p1  = {1'b0, frame_len_hold} + 9'd1;
  assign len_p2  = {1'b0, frame_len_hold} + 9'd2;

  always_comb begin
    status                 = ST_NONE;
    running_crc_next       = running_crc;
    sender_hold_next       = sender_hold;
    frame_len_hold_next    = frame_len_hold;
    received_crc_hold_next = received_crc_hold;
    case (byte_position)
      POS_SYNC: begin
        running_crc_next = crc_fed;
        if ((previous_status == ST_GOOD || previous_status == ST_BAD) &&
            bus_byte == ACK_BYTE) begin
          status = ST_ACK;
        end else if (bus_byte != SYNC_BYTE) begin
          status = ST_ERROR;
        end
      end
      POS_SENDER: begin
        running_crc_next = crc_fed;
        if (bus_byte[7]) begin
          status = ST_TOKEN;
        end
        sender_hold_next = bus_byte[6:0];
      end
      POS_LENGTH: begin
        running_crc_next = crc_fed;
        if (bus_byte == 8'd0) begin
          status = ST_EMPTY;
        end else if (bus_byte > MAX_LEN_8) begin
          status = ST_ERROR;
        end else begin
          frame_len_hold_next = bus_byte;
        end
      end
      POS_RECV: begin
        if (bus_byte[7]) begin
          status = ST_ERROR;
        end else if (byte_position <= frame_len_hold) begin
          running_crc_next = crc_fed;
        end
      end
      POS_EXT: begin
        if (byte_position <= frame_len_hold) begin
          running_crc_next = crc_fed;
        end
      end
      default: begin
        if (pos_ext < len_p1) begin
          running_crc_next = crc_fed;
        end else if (pos_ext == len_p1) begin
          received_crc_hold_next = {bus_byte, 8'h00};
        end else if (pos_ext == len_p2) begin
          received_crc_hold_next = received_crc_hold | {8'h00, bus_byte};
          status = (received_crc_hold_next == running_crc) ? ST_GOOD : ST_BAD;
        end
      end
    endcase

    byte_position_next = byte_position + 8'd1;
    if (byte_position_next >= OVF_POS_8) begin
      status = ST_ERROR;
    end
    previous_status_next = previous_status;
    if (status != ST_NONE) begin
      byte_position_next   = 8'd0;
      previous_status_next = status;
    end

    result.frame_status   = status;
    result.sender_address = sender_hold_next;
    result.frame_length   = (byte_position == POS_LENGTH) ? bus_byte : frame_len_hold_next;
    if (status == ST_GOOD || status == ST_BAD) begin
      result.received_crc = received_crc_hold_next;
      result.computed_crc = running_crc;
    end else begin
      result.received_crc = 16'h0000;
      result.computed_crc = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= 8'd0;
      frame_len_hold    <= 8'd0;
      previous_status   <= ST_NONE;
      sender_hold       <= 7'd0;
      received_crc_hold <= 16'h0000;
      running_crc       <= 16'h0000;
    end else if (step) begin
      byte_position     <= byte_position_next;
      frame_len_hold    <= frame_len_hold_next;
      previous_status   <= previous_status_next;
      sender_hold       <= sender_hold_next;
      received_crc_hold <= received_crc_hold_next;
      running_crc       <= running_crc_next;
    end
  end

endmodule
